FILE: hw/rtl/cr_pkg.sv
// ----------------------------------------------------------------------------
// cr_pkg
// Shared types and constants for the combination rank block: index widths,
// operation codes and the read request that the ranking sequencer sends to
// the binomial ROM.
// ----------------------------------------------------------------------------
package cr_pkg;

    // Row and column indices of the binomial table (rows up to 32 need 6 bits)
    localparam int IDX_W  = 6;
    // Width of the subset mask and of the rank
    localparam int DATA_W = 32;

    // Operation codes of an input transaction
    localparam logic OP_COLEX      = 1'b0;
    localparam logic OP_CUMULATIVE = 1'b1;

    // Read request into the binomial table: C(row, col)
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_rd_req;

endpackage

FILE: hw/rtl/combination_rank.sv
// Each transaction walks every mask bit, then in cumulative mode reads one offset term per
//   set bit before the result is registered.
// A new transaction is taken only once the last result is loaded into the output register;
//   the single table read port serves one set bit or one offset term per cycle.
// Reset: synchronous, active low; the binomial table is then built while the input
//   is stalled.
// ----------------------------------------------------------------------------
// combination_rank
// Colex rank of a subset mask, optionally offset by the count of all smaller
// subsets of an n-element set. At most one table read and one accumulate per cycle.
// ----------------------------------------------------------------------------
module combination_rank #(
    parameter int MASK_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_operation,
    input  logic [cr_pkg::DATA_W-1:0] i_subset_mask,
    input  logic [5:0]                i_set_size,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [cr_pkg::DATA_W-1:0] o_rank
);
    import cr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_OFFS  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [MASK_WIDTH-1:0] r_mask;
    logic                  r_op;
    logic [IDX_W-1:0]      r_n;
    logic [IDX_W-1:0]      r_p;
    logic [IDX_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_i;
    logic                  r_add;
    logic [DATA_W-1:0]     r_acc;
    logic                  r_out_valid;
    logic [DATA_W-1:0]     r_rank;

    t_rd_req               w_rd_req;
    logic [DATA_W-1:0]     w_rd_data;
    logic                  w_rom_ready;
    logic                  w_accept;
    logic                  w_load_out;
    logic [IDX_W-1:0]      w_count_inc;
    logic                  w_scan_last;

    cr_binom_rom #(
        .MASK_WIDTH (MASK_WIDTH)
    ) u_rom (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_req  (w_rd_req),
        .o_rd_data (w_rd_data),
        .o_ready   (w_rom_ready)
    );

    assign o_in_stall  = !(r_state == S_IDLE && w_rom_ready);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_load_out  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign w_count_inc = r_count + 1'b1;
    assign w_scan_last = (r_p == IDX_W'(MASK_WIDTH - 1));

    // Table read request: C(p, count+1) per set bit, then C(n, i) offsets
    always_comb begin
        w_rd_req.en  = 1'b0;
        w_rd_req.row = r_p;
        w_rd_req.col = w_count_inc;
        case (r_state)
            S_SCAN: begin
                w_rd_req.en = r_mask[0];
            end
            S_OFFS: begin
                w_rd_req.en  = 1'b1;
                w_rd_req.row = r_n;
                w_rd_req.col = r_i;
            end
            default: begin
                w_rd_req.en = 1'b0;
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_scan_last) begin
                    if (r_op == OP_CUMULATIVE && (r_count != '0 || r_mask[0])) begin
                        n_state = S_OFFS;
                    end else begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_OFFS: begin
                if (r_i + 1'b1 == r_count) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load_out) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_add       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_add   <= w_rd_req.en;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath: capture the transaction, walk the mask, accumulate lookups
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mask  <= i_subset_mask[MASK_WIDTH-1:0];
            r_op    <= i_operation;
            r_n     <= (i_set_size > IDX_W'(MASK_WIDTH)) ? IDX_W'(MASK_WIDTH) : i_set_size;
            r_p     <= '0;
            r_count <= '0;
            r_i     <= '0;
            r_acc   <= '0;
        end else begin
            if (r_add) begin
                r_acc <= r_acc + w_rd_data;
            end
            if (r_state == S_SCAN) begin
                r_mask <= r_mask >> 1;
                r_p    <= r_p + 1'b1;
                if (r_mask[0]) begin
                    r_count <= w_count_inc;
                end
            end
            if (r_state == S_OFFS) begin
                r_i <= r_i + 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_rank <= r_acc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rank      = r_rank;

`ifndef SYNTHESIS
    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_SCAN)
        else $error("accepted transaction did not start the scan");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= IDX_W'(MASK_WIDTH))
        else $error("set-bit count exceeds mask width");

    a_offs_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OFFS |-> r_i < r_count)
        else $error("offset index ran past the popcount");

    a_add_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_add |-> (r_state == S_SCAN || r_state == S_OFFS || r_state == S_DRAIN))
        else $error("table lookup landed outside the ranking pass");

    a_read_after_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_req.en |-> w_rom_ready)
        else $error("table read issued while the table is being built");
`endif

endmodule

FILE: hw/rtl/cr_binom_rom.sv
// ----------------------------------------------------------------------------
// cr_binom_rom
// Pascal-triangle table of C(row, col) held in a single-port-read memory.
// After reset the table is built row by row from the previous row, with a read
// and a write phase per entry; o_ready rises once the last entry is written.
// ----------------------------------------------------------------------------
module cr_binom_rom #(
    parameter int MASK_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cr_pkg::t_rd_req       i_rd_req,
    output logic [cr_pkg::DATA_W-1:0] o_rd_data,
    output logic                  o_ready
);
    import cr_pkg::*;

    localparam int DIM   = MASK_WIDTH + 1;
    localparam int DEPTH = DIM * DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_prev;
    logic              r_busy;
    logic              r_phase;
    logic [IDX_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_col;

    logic              w_we;
    logic              w_re;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    logic [DATA_W-1:0] w_wdata;
    logic [IDX_W-1:0]  w_rrow;
    logic [IDX_W-1:0]  w_rcol;

    // Build sweep: phase 0 reads C(row-1, col), phase 1 writes C(row, col)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_phase <= 1'b0;
            r_row   <= '0;
            r_col   <= '0;
        end else if (r_busy) begin
            r_phase <= ~r_phase;
            if (r_phase) begin
                if (r_col == IDX_W'(MASK_WIDTH)) begin
                    r_col <= '0;
                    if (r_row == IDX_W'(MASK_WIDTH)) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // Left neighbor from the previous row, C(row-1, col-1)
    always_ff @(posedge i_clk) begin
        if (r_busy && r_phase) begin
            r_prev <= r_rd_data;
        end
    end

    // New entry: row 0 is a single one, later rows add the two parents
    always_comb begin
        if (r_row == '0) begin
            w_wdata = (r_col == '0) ? DATA_W'(1) : '0;
        end else begin
            w_wdata = r_rd_data + ((r_col == '0) ? '0 : r_prev);
        end
    end

    assign w_we    = r_busy && r_phase;
    assign w_waddr = AW'(int'(r_row) * DIM + int'(r_col));

    // Read port shared by the build sweep and the ranking sequencer
    always_comb begin
        if (r_busy) begin
            w_re   = !r_phase && (r_row != '0);
            w_rrow = r_row - 1'b1;
            w_rcol = r_col;
        end else begin
            w_re   = i_rd_req.en;
            w_rrow = i_rd_req.row;
            w_rcol = i_rd_req.col;
        end
    end

    assign w_raddr = AW'(int'(w_rrow) * DIM + int'(w_rcol));

    // Memory array, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_busy;

endmodule
